// ===== design/assert_macros.svh =====
// Shared assertion macros. Each one uses the clk and rst of the module it sits in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition must never hold
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/pdhx_pkg.sv =====
// ----------------------------------------------------------------------------
// pdhx_pkg
// Shared types and constants of the dictionary hex string extractor.
// ----------------------------------------------------------------------------
package pdhx_pkg;

  localparam int KEY_MAX_BYTES = 16;
  localparam int OUT_MAX_BYTES = 256;

  // Look-ahead window
  localparam int WIN_DEPTH = 16;
  localparam int WIN_IDX_W = 4;
  localparam int FILL_W    = 5;
  localparam int SKIP_W    = 4;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = 2;
  localparam int Q_CNT_W = 3;

  localparam int COUNT_W    = 9;
  localparam int KEYLEN_W   = 5;
  localparam int DEPTH_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd3;

  // Characters
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // "endobj", first character in the low byte
  localparam int         ENDOBJ_LEN = 6;
  localparam logic [47:0] ENDOBJ_PAT = 48'h6A626F646E65;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_DICT  = 3'd1;
  localparam logic [2:0] ST_NESTED   = 3'd2;
  localparam logic [2:0] ST_NO_KEY   = 3'd3;
  localparam logic [2:0] ST_NO_OPEN  = 3'd4;
  localparam logic [2:0] ST_NO_CLOSE = 3'd5;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // One classified buffer byte
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       is_hex;
    logic [3:0] nib;
    logic       is_ws;
    logic       is_lt;
    logic       is_gt;
  } sym_t;

  typedef enum logic [7:0] {
    PH_SEEK = 8'b0000_0001,
    PH_TOP  = 8'b0000_0010,
    PH_CHK  = 8'b0000_0100,
    PH_NEST = 8'b0000_1000,
    PH_KEY  = 8'b0001_0000,
    PH_WS   = 8'b0010_0000,
    PH_HEX  = 8'b0100_0000,
    PH_DONE = 8'b1000_0000
  } phase_t;

endpackage

// ===== design/pdf_dict_hex_string_extract_top.sv =====
// Throughput: one byte per cycle within a buffer while the output is not stalled; at each
// buffer end the input stalls once the queue fills, until the window has drained and the
// status is out. Flow: an accepted byte is registered in the queue, then in the window,
// and is walked once 15 later bytes are held; after the final byte the window drains its
// bytes and a step decides the status, which is then registered. Output stalls hold the
// walk. Reset: clears run state, key_length 1.
// ----------------------------------------------------------------------------
// pdf_dict_hex_string_extract_top
// Extracts the hex string value of a configured key from a dictionary.
// ----------------------------------------------------------------------------
module pdf_dict_hex_string_extract_top
  import pdhx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  result_kind,
  output logic [7:0]            out_byte,
  output logic [2:0]            status,
  output logic [COUNT_W-1:0]    out_count,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_full, q_push, q_empty, q_pop;
  sym_t q_data, q_head;

  pdhx_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  pdhx_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  pdhx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .out_byte    (out_byte),
    .status      (status),
    .out_count   (out_count),
    .out_last    (out_last)
  );

endmodule

// ===== design/pdhx_front.sv =====
// ----------------------------------------------------------------------------
// pdhx_front
// Accepts buffer bytes and classifies them for the walk.
// ----------------------------------------------------------------------------
module pdhx_front
  import pdhx_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output sym_t       q_data
);

  logic is_dec;
  logic is_alpha;

  // Hold the input while the queue is full
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Classify hex digits, whitespace and brackets
  assign is_dec   = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign is_alpha = ((in_byte >= CH_UA) && (in_byte <= CH_UF)) ||
                    ((in_byte >= CH_LA) && (in_byte <= CH_LF_HEX));

  always_comb begin
    q_data.code   = in_byte;
    q_data.last   = in_last;
    q_data.is_hex = is_dec || is_alpha;
    q_data.nib    = is_dec ? in_byte[3:0] : (in_byte[3:0] + 4'd9);
    q_data.is_ws  = (in_byte == CH_SP) || (in_byte == CH_TAB) ||
                    (in_byte == CH_CR) || (in_byte == CH_LF);
    q_data.is_lt  = (in_byte == CH_LT);
    q_data.is_gt  = (in_byte == CH_GT);
  end

endmodule

// ===== design/pdhx_queue.sv =====
// ----------------------------------------------------------------------------
// pdhx_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdhx_queue
  import pdhx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  sym_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output sym_t head
);

  sym_t               entries [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_ptr;
  logic [Q_IDX_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full  = (count == Q_CNT_W'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  `ASSERT_NEVER(a_q_count_bound, count > Q_CNT_W'(Q_DEPTH))
  `ASSERT_NEVER(a_q_pop_empty, pop && empty)

endmodule

// ===== design/pdhx_back.sv =====
// ----------------------------------------------------------------------------
// pdhx_back
// Walks the dictionary over a 16-byte look-ahead window, decodes the hex
// string and produces data and status results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdhx_back
  import pdhx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_empty,
  input  sym_t                  q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  result_kind,
  output logic [7:0]            out_byte,
  output logic [2:0]            status,
  output logic [COUNT_W-1:0]    out_count,
  output logic                  out_last
);

  // Configuration
  logic [63:0]          key_low;
  logic [63:0]          key_high;
  logic [KEYLEN_W-1:0]  key_length;
  logic [COUNT_W-1:0]   max_out_len;

  // Run state
  phase_t               phase, phase_next;
  sym_t                 win [WIN_DEPTH];
  sym_t                 win_next [WIN_DEPTH];
  logic [FILL_W-1:0]    fill, fill_next;
  logic                 end_in, end_in_next;
  logic [SKIP_W-1:0]    skip, skip_next;
  logic [DEPTH_W-1:0]   depth, depth_next;
  logic [3:0]           high_nibble, high_nibble_next;
  logic                 nibble_pending, nibble_pending_next;
  logic [COUNT_W-1:0]   decoded_count, decoded_count_next;
  logic [2:0]           held_status;

  logic                 go, proc, fin_stat;
  logic                 a2, lt2, gt2, endobj_hit, key_hit, key_eval;
  logic                 pop, take, emit_data, do_finish;
  logic [2:0]           fin_code, final_status;
  logic [KEYLEN_W-1:0]  kl;
  logic [COUNT_W-1:0]   lim;
  logic [127:0]         key_all;
  logic [7:0]           data_byte;
  logic [WIN_IDX_W-1:0] wr_idx;
  logic [FILL_W-1:0]    wr_pos;
  logic                 out_load;

  // Move on when the output slot is free or being taken
  assign go       = !out_valid || !out_stall;
  assign proc     = go && (fill != '0) && ((fill == FILL_W'(WIN_DEPTH)) || end_in);
  assign fin_stat = go && end_in && (fill == '0);

  // Effective key length and output limit
  assign kl  = (key_length == '0) ? KEYLEN_W'(1) :
               (key_length > KEYLEN_W'(KEY_MAX_BYTES)) ? KEYLEN_W'(KEY_MAX_BYTES) :
               key_length;
  assign lim = (max_out_len > COUNT_W'(OUT_MAX_BYTES)) ? COUNT_W'(OUT_MAX_BYTES) :
               max_out_len;
  assign key_all = {key_high, key_low};

  // Pattern checks at the head of the window
  assign a2  = fill >= FILL_W'(2);
  assign lt2 = a2 && win[0].is_lt && win[1].is_lt;
  assign gt2 = a2 && win[0].is_gt && win[1].is_gt;

  always_comb begin
    endobj_hit = (fill >= FILL_W'(ENDOBJ_LEN));
    for (int i = 0; i < ENDOBJ_LEN; i++) begin
      if (win[i].code != ENDOBJ_PAT[8*i +: 8]) endobj_hit = 1'b0;
    end
  end

  always_comb begin
    key_hit = ({1'b0, kl} <= {1'b0, fill});
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if ((KEYLEN_W'(i) < kl) && (win[i].code != key_all[8*i +: 8])) key_hit = 1'b0;
    end
  end

  // Walk step for the byte at the head of the window
  always_comb begin
    pop                 = 1'b0;
    emit_data           = 1'b0;
    do_finish           = 1'b0;
    key_eval            = 1'b0;
    fin_code            = ST_OK;
    phase_next          = phase;
    skip_next           = skip;
    depth_next          = depth;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    decoded_count_next  = decoded_count;
    data_byte           = {high_nibble, win[0].nib};
    if (proc) begin
      if (skip != '0) begin
        pop       = 1'b1;
        skip_next = skip - 1'b1;
      end else begin
        unique case (phase)
          PH_SEEK: begin
            if (!a2) begin
              do_finish = 1'b1;
              fin_code  = ST_NO_DICT;
            end else if (lt2) begin
              pop        = 1'b1;
              skip_next  = SKIP_W'(1);
              phase_next = PH_TOP;
            end else if (endobj_hit) begin
              do_finish = 1'b1;
              fin_code  = ST_NO_DICT;
            end else begin
              pop = 1'b1;
            end
          end
          PH_TOP, PH_CHK: begin
            if (!a2 || ((phase == PH_CHK) && gt2)) begin
              do_finish = 1'b1;
              fin_code  = ST_NO_KEY;
            end else if (lt2) begin
              pop        = 1'b1;
              skip_next  = SKIP_W'(1);
              depth_next = DEPTH_W'(1);
              phase_next = PH_NEST;
            end else begin
              key_eval = 1'b1;
            end
          end
          PH_NEST: begin
            if (!a2) begin
              do_finish = 1'b1;
              fin_code  = ST_NESTED;
            end else if (lt2) begin
              if (depth == '1) begin
                do_finish = 1'b1;
                fin_code  = ST_NESTED;
              end else begin
                pop        = 1'b1;
                skip_next  = SKIP_W'(1);
                depth_next = depth + 1'b1;
              end
            end else if (gt2) begin
              pop        = 1'b1;
              skip_next  = SKIP_W'(1);
              depth_next = depth - 1'b1;
              if (depth == DEPTH_W'(1)) phase_next = PH_KEY;
            end else begin
              pop = 1'b1;
            end
          end
          PH_KEY: begin
            key_eval = 1'b1;
          end
          PH_WS: begin
            if (win[0].is_ws) begin
              pop = 1'b1;
            end else if (win[0].is_lt) begin
              pop        = 1'b1;
              phase_next = PH_HEX;
            end else begin
              do_finish = 1'b1;
              fin_code  = ST_NO_OPEN;
            end
          end
          PH_HEX: begin
            if (decoded_count >= lim) begin
              do_finish = 1'b1;
              fin_code  = win[0].is_gt ? ST_OK : ST_NO_CLOSE;
            end else if (win[0].is_gt) begin
              do_finish = 1'b1;
              fin_code  = ST_OK;
            end else begin
              pop = 1'b1;
              if (win[0].is_hex) begin
                if (nibble_pending) begin
                  nibble_pending_next = 1'b0;
                  decoded_count_next  = decoded_count + 1'b1;
                  emit_data           = 1'b1;
                end else begin
                  high_nibble_next    = win[0].nib;
                  nibble_pending_next = 1'b1;
                end
              end
            end
          end
          PH_DONE: begin
            pop = 1'b1;
          end
          default: begin
            pop = 1'b1;
          end
        endcase
        // Compare the key at this position
        if (key_eval) begin
          pop = 1'b1;
          if (key_hit) begin
            skip_next  = SKIP_W'(kl - 1'b1);
            phase_next = PH_WS;
          end else begin
            phase_next = PH_CHK;
          end
        end
      end
    end
    if (do_finish) phase_next = PH_DONE;
  end

  // Refill the window from the queue
  assign take   = !q_empty && !end_in && ((fill != FILL_W'(WIN_DEPTH)) || pop);
  assign q_pop  = take;
  assign wr_pos = pop ? (fill - 1'b1) : fill;
  assign wr_idx = wr_pos[WIN_IDX_W-1:0];
  assign fill_next   = fill - FILL_W'(pop) + FILL_W'(take);
  assign end_in_next = end_in || (take && q_head.last);

  always_comb begin
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_next[i] = pop ? win[i+1] : win[i];
    end
    win_next[WIN_DEPTH-1] = win[WIN_DEPTH-1];
    if (take) win_next[wr_idx] = q_head;
  end

  // Final status for the buffer
  always_comb begin
    if (phase == PH_DONE)      final_status = held_status;
    else if (phase == PH_SEEK) final_status = ST_NO_DICT;
    else if (phase == PH_NEST) final_status = ST_NESTED;
    else                       final_status = ST_NO_KEY;
  end

  assign out_load = emit_data || fin_stat;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low        <= '0;
      key_high       <= '0;
      key_length     <= KEYLEN_W'(1);
      max_out_len    <= COUNT_W'(OUT_MAX_BYTES);
      phase          <= PH_SEEK;
      fill           <= '0;
      end_in         <= 1'b0;
      skip           <= '0;
      depth          <= '0;
      high_nibble    <= '0;
      nibble_pending <= 1'b0;
      decoded_count  <= '0;
      held_status    <= ST_OK;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LOW:  key_low     <= cfg_data;
          CFG_KEY_HIGH: key_high    <= cfg_data;
          CFG_KEY_LEN:  key_length  <= cfg_data[KEYLEN_W-1:0];
          CFG_MAX_LEN:  max_out_len <= cfg_data[COUNT_W-1:0];
          default:      ;
        endcase
      end
      if (fin_stat) begin
        // Drop run state for the next buffer
        phase          <= PH_SEEK;
        fill           <= '0;
        end_in         <= 1'b0;
        skip           <= '0;
        depth          <= '0;
        high_nibble    <= '0;
        nibble_pending <= 1'b0;
        decoded_count  <= '0;
        held_status    <= ST_OK;
      end else begin
        phase          <= phase_next;
        fill           <= fill_next;
        end_in         <= end_in_next;
        skip           <= skip_next;
        depth          <= depth_next;
        high_nibble    <= high_nibble_next;
        nibble_pending <= nibble_pending_next;
        decoded_count  <= decoded_count_next;
        if (do_finish) held_status <= fin_code;
      end
      if (go) out_valid <= out_load;
    end
  end

  // Window and result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win[i] <= win_next[i];
    end
    if (go && out_load) begin
      if (fin_stat) begin
        result_kind <= KIND_STATUS;
        out_byte    <= '0;
        status      <= final_status;
        out_count   <= (final_status == ST_OK) ? decoded_count : '0;
        out_last    <= 1'b1;
      end else begin
        result_kind <= KIND_DATA;
        out_byte    <= data_byte;
        status      <= ST_OK;
        out_count   <= decoded_count_next;
        out_last    <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_fill_bound, fill > FILL_W'(WIN_DEPTH))
  `ASSERT_IMPLIES(a_nest_nonzero, phase == PH_NEST, depth != '0)
  `ASSERT_NEXT(a_status_restarts, fin_stat, (fill == '0) && !end_in && (phase == PH_SEEK))

endmodule
